@@ rtl/dsc_pkg.sv @@
// Shared types and constants for the distinct subsequence counter.
`default_nettype none

package dsc_pkg;

   // Field widths.
   localparam int LIMB_W = 14;
   localparam int CHAR_W = 8;
   localparam int CMD_W  = 2;
   localparam int SUM_W  = LIMB_W + 1;

   // One decimal limb holds 0 to 9999.
   localparam logic [SUM_W-1:0] LIMB_BASE = 15'd10000;

   // Command codes of a request beat.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

   // Request beat.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
   } dsc_req_type;

   // Response beat.
   typedef struct packed {
      logic [LIMB_W-1:0] limb;
      logic              last;
   } dsc_rsp_type;

   // Controls broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              clear;
      logic              text_step;
      logic              first;
      logic              back_step;
      logic [CHAR_W-1:0] ch;
   } dsc_ctl_type;

endpackage

`default_nettype wire

@@ rtl/distinct_subsequence_counter.sv @@
// Top level of the distinct subsequence counter: sequencer, cell chain and response register.
`default_nettype none

// Counts the occurrences of a loaded pattern as a subsequence of a streamed text. Each pattern
// character lives in its own cell together with its prefix count, held as LIMBS decimal limbs in
// a ring. Clear and append beats need no walk. A text beat on a nonempty pattern starts a walk
// over the LIMBS limbs in which every cell whose character matches adds its left neighbor's count
// one limb per cycle through its own limb adder, all cells at once, so the walk does not depend
// on the pattern length. A finish beat walks the selected count from the top limb down, holding
// its step while the response side stalls a waiting limb, and sends one beat per limb from the
// most significant nonzero limb; last marks limb zero. Counts wrap modulo 10^(4*LIMBS). No
// clearing pass follows reset.
module distinct_subsequence_counter
   import dsc_pkg::*;
#(
   parameter int PATTERN_MAX = 128,
   parameter int LIMBS       = 30
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire dsc_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output dsc_rsp_type      rsp_data
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CTR_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam logic [CTR_W-1:0] LIMB_TOP = CTR_W'(LIMBS - 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TEXT = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CTR_W-1:0]  ctr_ff, ctr_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              seen_ff, seen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dsc_rsp_type       rsp_data_ff, rsp_data_in;

   dsc_ctl_type       ctl;
   logic              req_accept;
   logic              append_ok;
   logic              emit_load;
   logic              out_free;
   logic [LEN_W-1:0]  len_m1;
   logic [LIMB_W-1:0] src_limb;
   logic [LIMB_W-1:0] heads [PATTERN_MAX];
   logic [LIMB_W-1:0] tops  [PATTERN_MAX];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Chain of cells; the first one sees a constant count of one.
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic [LIMB_W-1:0] prev;
      logic              load;

      if (j == 0) begin : g_first
         assign prev = LIMB_W'(ctr_ff == '0);
      end else begin : g_rest
         assign prev = heads[j-1];
      end

      assign load = append_ok && (len_ff == LEN_W'(j));

      dsc_cell #(
         .LIMBS (LIMBS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .load      (load),
         .prev_limb (prev),
         .head_limb (heads[j]),
         .top_limb  (tops[j])
      );
   end

   // Limb source for readout: the last valid cell, or the constant one for an empty pattern.
   always_comb begin
      len_m1   = len_ff - LEN_W'(1);
      src_limb = (len_ff == '0) ? LIMB_W'(ctr_ff == '0) : tops[len_m1[IDX_W-1:0]];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      ctr_in        = ctr_ff;
      ch_in         = ch_ff;
      seen_in       = seen_ff;
      append_ok     = 1'b0;
      emit_load     = 1'b0;
      ctl.clear     = 1'b0;
      ctl.text_step = 1'b0;
      ctl.first     = 1'b0;
      ctl.back_step = 1'b0;
      ctl.ch        = (state_ff == ST_IDLE) ? req_data.ch : ch_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     ctl.clear = 1'b1;
                     len_in    = '0;
                  end
                  CMD_APPEND: begin
                     if (len_ff != LEN_FULL) begin
                        append_ok = 1'b1;
                        len_in    = len_ff + LEN_W'(1);
                     end
                  end
                  CMD_TEXT: begin
                     if (len_ff != '0) begin
                        state_in = ST_TEXT;
                        ctr_in   = '0;
                        ch_in    = req_data.ch;
                     end
                  end
                  CMD_FINISH: begin
                     state_in = ST_EMIT;
                     ctr_in   = LIMB_TOP;
                     seen_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TEXT: begin
            ctl.text_step = 1'b1;
            ctl.first     = (ctr_ff == '0);
            if (ctr_ff == LIMB_TOP) begin
               state_in = ST_IDLE;
            end else begin
               ctr_in = ctr_ff + CTR_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ctl.back_step = 1'b1;
               if ((src_limb != '0) || seen_ff || (ctr_ff == '0)) begin
                  emit_load = 1'b1;
                  seen_in   = 1'b1;
               end
               if (ctr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ctr_in = ctr_ff - CTR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in     = out_free ? emit_load : rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      if (emit_load) begin
         rsp_data_in.limb = src_limb;
         rsp_data_in.last = (ctr_ff == '0);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctr_ff      <= ctr_in;
      ch_ff       <= ch_in;
      seen_ff     <= seen_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The pattern length never passes the cell count.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("pattern length beyond cell count");

   // A text walk ends after its top limb.
   a_text_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEXT && ctr_ff == LIMB_TOP) |=> state_ff == ST_IDLE)
      else $error("text walk overran the limb count");

   // Loading the least significant limb ends the readout.
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (emit_load && ctr_ff == '0) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_data_ff.last))
      else $error("readout did not end on the last limb");

   // Every limb sent is a proper decimal limb.
   a_limb_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_data_ff.limb} < LIMB_BASE))
      else $error("limb out of decimal range");

   // A finish beat always starts a readout.
   a_finish_emit: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.cmd == CMD_FINISH) |=> state_ff == ST_EMIT)
      else $error("finish beat did not start a readout");

endmodule

`default_nettype wire

@@ rtl/dsc_cell.sv @@
// One pattern cell: a pattern character and its prefix count as a ring of decimal limbs.
`default_nettype none

module dsc_cell
   import dsc_pkg::*;
#(
   parameter int LIMBS = 30
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dsc_ctl_type       ctl,
   input  wire logic              load,
   input  wire logic [LIMB_W-1:0] prev_limb,
   output logic      [LIMB_W-1:0] head_limb,
   output logic      [LIMB_W-1:0] top_limb
);

   logic [LIMB_W-1:0] limbs_ff [LIMBS];
   logic [LIMB_W-1:0] limbs_in [LIMBS];
   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;
   logic              carry_ff;
   logic              carry_in;
   logic              vld_ff;
   logic              vld_in;

   logic              match;
   logic [LIMB_W-1:0] addend;
   logic              carry_use;
   logic [SUM_W-1:0]  sum;
   logic              wrap;
   logic [LIMB_W-1:0] new_limb;

   // The neighbor always sees the registered head limb of this ring, the limb of the current step.
   assign head_limb = limbs_ff[0];
   assign top_limb  = limbs_ff[LIMBS-1];

   // Limb adder: own limb plus the neighbor's limb on a character match.
   always_comb begin
      match     = vld_ff && (char_ff == ctl.ch);
      addend    = match ? prev_limb : '0;
      carry_use = ctl.first ? 1'b0 : carry_ff;
      sum       = {1'b0, limbs_ff[0]} + {1'b0, addend} + SUM_W'(carry_use);
      wrap      = (sum >= LIMB_BASE);
      new_limb  = wrap ? LIMB_W'(sum - LIMB_BASE) : sum[LIMB_W-1:0];
   end

   // Ring update: cleared on load, forward while adding, backward while reading out.
   always_comb begin
      limbs_in = limbs_ff;
      if (load) begin
         for (int i = 0; i < LIMBS; i++) begin
            limbs_in[i] = '0;
         end
      end else if (ctl.text_step) begin
         for (int i = 0; i < LIMBS - 1; i++) begin
            limbs_in[i] = limbs_ff[i+1];
         end
         limbs_in[LIMBS-1] = new_limb;
      end else if (ctl.back_step) begin
         for (int i = 1; i < LIMBS; i++) begin
            limbs_in[i] = limbs_ff[i-1];
         end
         limbs_in[0] = limbs_ff[LIMBS-1];
      end
   end

   // Character, carry and valid flag.
   always_comb begin
      char_in  = load ? ctl.ch : char_ff;
      carry_in = ctl.text_step ? wrap : carry_ff;
      vld_in   = vld_ff;
      if (ctl.clear) begin
         vld_in = 1'b0;
      end else if (load) begin
         vld_in = 1'b1;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      limbs_ff <= limbs_in;
      char_ff  <= char_in;
      carry_ff <= carry_in;
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule

`default_nettype wire
